// ----- hdl/sflg_pkg.sv -----
// Package for the stereo flanger: sample widths, register indexes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package sflg_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CFG_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = 17;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LFO_AMP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LFO_INC    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 2'd3;

    localparam logic [16:0] RST_BASE_DELAY = 17'd49152;
    localparam logic [16:0] RST_LFO_AMP    = 17'd44237;
    localparam logic [20:0] RST_LFO_INC    = 21'd107374;
    localparam logic [15:0] RST_FEEDBACK   = 16'd12714;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DELAY,
        ST_RD0,
        ST_RD1,
        ST_DIV_INIT,
        ST_DIV,
        ST_AP_MUL,
        ST_AP_SUM,
        ST_FB_MUL,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic calc_delay;
        logic rd_next;
        logic cap_x0;
        logic div_init;
        logic div_step;
        logic ap_mul;
        logic ap_sum;
        logic fb_mul;
        logic write_back;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } status_t;

    // Clamp a 28-bit signed value to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat28(input logic signed [27:0] v);
        logic signed [27:0] hi;
        logic signed [27:0] lo;
        hi = 28'sd8388607;
        lo = -28'sd8388608;
        if (v > hi)
            return SAMPLE_W'(hi);
        else if (v < lo)
            return SAMPLE_W'(lo);
        else
            return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ----- hdl/sflg_ctrl.sv -----
// Sequencing controller for the stereo flanger.
// Depends on sflg_pkg; drives commands into sflg_datapath.
module sflg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sflg_pkg::status_t status,
    output sflg_pkg::cmd_t    cmd
);

    sflg_pkg::state_t                   state_reg, state_next;
    logic [sflg_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sflg_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            sflg_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                    state_next = sflg_pkg::ST_IDLE;
            end
            sflg_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sflg_pkg::ST_MUL_LO;
                end
            end
            sflg_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = sflg_pkg::ST_MUL_HI;
            end
            sflg_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = sflg_pkg::ST_DELAY;
            end
            sflg_pkg::ST_DELAY:
            begin
                cmd.calc_delay = 1'b1;
                state_next     = sflg_pkg::ST_RD0;
            end
            sflg_pkg::ST_RD0:
            begin
                state_next = sflg_pkg::ST_RD1;
            end
            sflg_pkg::ST_RD1:
            begin
                cmd.rd_next = 1'b1;
                cmd.cap_x0  = 1'b1;
                state_next  = sflg_pkg::ST_DIV_INIT;
            end
            sflg_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = sflg_pkg::ST_DIV;
            end
            sflg_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sflg_pkg::DIV_CNT_W'(sflg_pkg::DIV_STEPS - 1))
                    state_next = sflg_pkg::ST_AP_MUL;
            end
            sflg_pkg::ST_AP_MUL:
            begin
                cmd.ap_mul = 1'b1;
                state_next = sflg_pkg::ST_AP_SUM;
            end
            sflg_pkg::ST_AP_SUM:
            begin
                cmd.ap_sum = 1'b1;
                state_next = sflg_pkg::ST_FB_MUL;
            end
            sflg_pkg::ST_FB_MUL:
            begin
                cmd.fb_mul = 1'b1;
                state_next = sflg_pkg::ST_WRITE;
            end
            sflg_pkg::ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.write_back = 1'b1;
                    state_next     = sflg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sflg_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- hdl/sflg_datapath.sv -----
// Datapath of the stereo flanger: config registers, LFO, delay arithmetic,
// coefficient divider, delay-line memories, allpass and output register.
// Depends on sflg_pkg; controlled by sflg_ctrl.
module sflg_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sflg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sflg_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [sflg_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [sflg_pkg::SAMPLE_W-1:0] right_in,
    output logic signed [sflg_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sflg_pkg::SAMPLE_W-1:0] right_out,
    output logic                                out_valid,
    input  logic                                out_stall,
    input  sflg_pkg::cmd_t                      cmd,
    output sflg_pkg::status_t                   status
);

    logic [16:0] base_reg;
    logic [16:0] amp_reg;
    logic [20:0] inc_reg;
    logic [15:0] fb_reg;
    logic [31:0] phase_reg;
    logic [sflg_pkg::ADDR_W-1:0] wp_reg;
    logic          out_valid_reg;

    logic [31:0] tri_val;
    logic [32:0] p_lo_reg;
    logic [32:0] p_hi_reg;
    logic [48:0] lfo_sum;
    logic [17:0] delay_sum;
    logic [7:0]  delay_reg;
    logic [sflg_pkg::ADDR_W-1:0] rd_reg;
    logic [sflg_pkg::ADDR_W-1:0] rn;
    logic [sflg_pkg::ADDR_W-1:0] raddr;

    logic [8:0]  den_reg;
    logic [9:0]  rem_reg;
    logic [16:0] numq_reg;
    logic [8:0]  den_init;
    logic [8:0]  num_hi;
    logic [24:0] num_init;
    logic [9:0]  div_t;

    assign tri_val = phase_reg[31] ? (32'd0 - phase_reg) : phase_reg;
    assign lfo_sum = {p_hi_reg, 16'd0} + {16'd0, p_lo_reg};
    assign delay_sum = {1'b0, base_reg} + lfo_sum[48:31];
    assign rn      = rd_reg + 1'b1;
    assign raddr   = cmd.rd_next ? rn : rd_reg;
    assign den_init = {1'b1, delay_reg};
    assign num_hi   = 9'd256 - {1'b0, delay_reg};
    assign num_init = {num_hi, 16'd0} + {17'd0, den_init[8:1]};
    assign div_t    = {rem_reg[8:0], numq_reg[16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= sflg_pkg::RST_BASE_DELAY;
            amp_reg       <= sflg_pkg::RST_LFO_AMP;
            inc_reg       <= sflg_pkg::RST_LFO_INC;
            fb_reg        <= sflg_pkg::RST_FEEDBACK;
            phase_reg     <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sflg_pkg::REG_BASE_DELAY: base_reg <= cfg_data[16:0];
                    sflg_pkg::REG_LFO_AMP:    amp_reg  <= cfg_data[16:0];
                    sflg_pkg::REG_LFO_INC:    inc_reg  <= cfg_data[20:0];
                    sflg_pkg::REG_FEEDBACK:   fb_reg   <= cfg_data[15:0];
                    default:                  ;
                endcase
            end
            if (cmd.accept)
                phase_reg <= phase_reg + {11'd0, inc_reg};
            if (cmd.clr_wr || cmd.write_back)
                wp_reg <= wp_reg + 1'b1;
            if (cmd.write_back)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
            p_lo_reg <= {17'd0, tri_val[15:0]} * {16'd0, amp_reg};
        if (cmd.mul_hi)
            p_hi_reg <= {17'd0, tri_val[31:16]} * {16'd0, amp_reg};
        if (cmd.calc_delay)
        begin
            delay_reg <= delay_sum[7:0];
            rd_reg    <= wp_reg - delay_sum[17:8] - 1'b1;
        end
        if (cmd.div_init)
        begin
            den_reg  <= den_init;
            rem_reg  <= {2'd0, num_init[24:17]};
            numq_reg <= num_init[16:0];
        end
        else if (cmd.div_step)
        begin
            if (div_t >= {1'b0, den_reg})
            begin
                rem_reg  <= div_t - {1'b0, den_reg};
                numq_reg <= {numq_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg  <= div_t;
                numq_reg <= {numq_reg[15:0], 1'b0};
            end
        end
    end

    logic signed [sflg_pkg::SAMPLE_W-1:0] ch_in  [2];
    logic signed [sflg_pkg::SAMPLE_W-1:0] ch_out [2];

    assign ch_in[0]  = left_in;
    assign ch_in[1]  = right_in;
    assign left_out  = ch_out[0];
    assign right_out = ch_out[1];
    assign out_valid = out_valid_reg;

    assign status.clr_last = (wp_reg == {sflg_pkg::ADDR_W{1'b1}});
    assign status.out_free = !out_valid_reg || !out_stall;

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_ch
        logic [sflg_pkg::SAMPLE_W-1:0]        line_mem [sflg_pkg::DEPTH];
        logic signed [sflg_pkg::SAMPLE_W-1:0] q_reg;
        logic signed [sflg_pkg::SAMPLE_W-1:0] in_reg;
        logic signed [sflg_pkg::SAMPLE_W-1:0] x0_reg;
        logic signed [sflg_pkg::SAMPLE_W-1:0] x1_reg;
        logic signed [sflg_pkg::SAMPLE_W-1:0] last_reg;
        logic signed [sflg_pkg::SAMPLE_W-1:0] y_reg;
        logic signed [sflg_pkg::SAMPLE_W-1:0] out_reg;
        logic signed [42:0]   ap_prod_reg;
        logic signed [40:0]   fb_prod_reg;
        logic signed [24:0]   diff;
        logic signed [42:0]   ap_sh;
        logic signed [27:0]   y_sum;
        logic signed [40:0]   fb_sh;
        logic signed [27:0]   w_sum;
        logic signed [sflg_pkg::SAMPLE_W:0]   o_sum;
        logic [sflg_pkg::SAMPLE_W-1:0]        wdata;

        assign diff  = {x1_reg[sflg_pkg::SAMPLE_W-1], x1_reg}
                     - {last_reg[sflg_pkg::SAMPLE_W-1], last_reg};
        assign ap_sh = (ap_prod_reg + 43'sd32768) >>> 16;
        assign y_sum = {{4{x0_reg[sflg_pkg::SAMPLE_W-1]}}, x0_reg} + ap_sh[27:0];
        assign fb_sh = (fb_prod_reg + 41'sd32768) >>> 16;
        assign w_sum = {{4{in_reg[sflg_pkg::SAMPLE_W-1]}}, in_reg}
                     + {{3{fb_sh[24]}}, fb_sh[24:0]};
        assign o_sum = {in_reg[sflg_pkg::SAMPLE_W-1], in_reg}
                     + {y_reg[sflg_pkg::SAMPLE_W-1], y_reg};
        assign wdata = cmd.clr_wr ? '0 : sflg_pkg::sat28(w_sum);
        assign ch_out[ch] = out_reg;

        always_ff @(posedge clk)
        begin
            q_reg <= line_mem[raddr];
            if (cmd.clr_wr || cmd.write_back)
                line_mem[wp_reg] <= wdata;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                last_reg <= '0;
            else if (cmd.ap_sum)
                last_reg <= sflg_pkg::sat28(y_sum);
        end

        always_ff @(posedge clk)
        begin
            if (cmd.accept)
                in_reg <= ch_in[ch];
            if (cmd.cap_x0)
                x0_reg <= q_reg;
            if (cmd.div_init)
                x1_reg <= q_reg;
            if (cmd.ap_mul)
                ap_prod_reg <= $signed({1'b0, numq_reg}) * diff;
            if (cmd.ap_sum)
                y_reg <= sflg_pkg::sat28(y_sum);
            if (cmd.fb_mul)
                fb_prod_reg <= y_reg * $signed({1'b0, fb_reg});
            if (cmd.write_back)
                out_reg <= o_sum[sflg_pkg::SAMPLE_W:1];
        end
    end

endmodule

// ----- hdl/stereo_flanger_top.sv -----
// Stereo flanger top level: controller plus datapath.
// Depends on sflg_pkg, sflg_ctrl and sflg_datapath.
//
// One stereo pair in, one flanged pair out, one item in work at a time: a new
// item is taken only once the last result is in the output register, and the
// bit-serial divider that forms the allpass coefficient takes most of the time
// per item. The output register lets a new item be accepted while the last
// result waits. After reset all 1024 entries of both delay lines are cleared,
// one entry per cycle, and no item is accepted until the clear is done;
// configuration writes are taken as ever.
module stereo_flanger_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sflg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sflg_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sflg_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [sflg_pkg::SAMPLE_W-1:0] right_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sflg_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sflg_pkg::SAMPLE_W-1:0] right_out
);

    sflg_pkg::cmd_t    cmd;
    sflg_pkg::status_t status;

    sflg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sflg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .left_in   (left_in),
        .right_in  (right_in),
        .left_out  (left_out),
        .right_out (right_out),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hdl/sflg_checker.sv -----
// Port-level checker for the stereo flanger, bound to the top level.
// Depends on stereo_flanger_top ports only.
module sflg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] left_out,
    input logic [23:0] right_out
);

    // one transaction in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction is in work");

    // a result only appears while a transaction is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_out) && $stable(right_out))
        else $error("stalled result changed");

endmodule

bind stereo_flanger_top sflg_checker u_sflg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
);

// ----- tb/sv/stereo_flanger_top_tb.sv -----
// Testbench for stereo_flanger_top: drives stereo sample pairs with random
// idling and stalls, predicts each flanged pair and checks it in a scoreboard.
// Depends on sflg_pkg and stereo_flanger_top.
`timescale 1ns / 100ps

class flanger_scoreboard;
    logic signed [23:0] left_line [1024];
    logic signed [23:0] right_line [1024];
    logic [9:0]   wr_ptr;
    logic [31:0]  phase;
    longint       left_last;
    longint       right_last;
    logic [16:0]  base_q8;
    logic [16:0]  amp_q8;
    logic [20:0]  phase_step;
    logic [15:0]  fb_gain;
    logic signed [23:0] left_expected [$];
    logic signed [23:0] right_expected [$];
    int unsigned  mismatches;
    int unsigned  pairs_checked;

    function new();
        for (int i = 0; i < 1024; i++)
        begin
            left_line[i] = '0;
            right_line[i] = '0;
        end
        wr_ptr = '0;
        phase = '0;
        left_last = 0;
        right_last = 0;
        base_q8 = sflg_pkg::RST_BASE_DELAY;
        amp_q8 = sflg_pkg::RST_LFO_AMP;
        phase_step = sflg_pkg::RST_LFO_INC;
        fb_gain = sflg_pkg::RST_FEEDBACK;
        mismatches = 0;
        pairs_checked = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [20:0] value);
        case (idx)
            sflg_pkg::REG_BASE_DELAY: base_q8 = value[16:0];
            sflg_pkg::REG_LFO_AMP:    amp_q8 = value[16:0];
            sflg_pkg::REG_LFO_INC:    phase_step = value;
            sflg_pkg::REG_FEEDBACK:   fb_gain = value[15:0];
            default:                  ;
        endcase
    endfunction

    function longint clamp(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function longint flange_channel(bit right_ch, longint x_in, logic [9:0] rd,
                                    logic [9:0] rn, longint a);
        longint x0;
        longint x1;
        longint last;
        longint y;
        logic signed [23:0] wval;
        x0 = right_ch ? longint'(right_line[rd]) : longint'(left_line[rd]);
        x1 = right_ch ? longint'(right_line[rn]) : longint'(left_line[rn]);
        last = right_ch ? right_last : left_last;
        y = clamp(x0 + ((a * (x1 - last) + 32768) >>> 16));
        wval = 24'(clamp(x_in + ((y * longint'(fb_gain) + 32768) >>> 16)));
        if (right_ch)
        begin
            right_last = y;
            right_line[wr_ptr] = wval;
        end
        else
        begin
            left_last = y;
            left_line[wr_ptr] = wval;
        end
        return (x_in + y) >>> 1;
    endfunction

    function void note_input(logic signed [23:0] l_in, logic signed [23:0] r_in);
        logic [63:0] tri_val;
        logic [63:0] dly;
        longint unsigned m;
        longint a;
        logic [9:0] rd;
        logic [9:0] rn;
        phase = phase + 32'(phase_step);
        tri_val = phase[31] ? (64'h1_0000_0000 - 64'(phase)) : 64'(phase);
        dly = 64'(base_q8) + ((tri_val * 64'(amp_q8)) >> 31);
        m = dly[7:0];
        a = longint'(((256 - m) * 65536 + (256 + m) / 2) / (256 + m));
        rd = wr_ptr - dly[17:8] - 10'd1;
        rn = rd + 10'd1;
        left_expected.push_back(24'(flange_channel(1'b0, l_in, rd, rn, a)));
        right_expected.push_back(24'(flange_channel(1'b1, r_in, rd, rn, a)));
        wr_ptr = wr_ptr + 10'd1;
    endfunction

    function void check_output(logic signed [23:0] l_out, logic signed [23:0] r_out);
        logic signed [23:0] le;
        logic signed [23:0] re;
        if (left_expected.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output pair %0d %0d", l_out, r_out);
            return;
        end
        le = left_expected.pop_front();
        re = right_expected.pop_front();
        pairs_checked++;
        if (le !== l_out || re !== r_out)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pair %0d: expected %0d %0d, got %0d %0d",
                         pairs_checked, le, re, l_out, r_out);
        end
    endfunction
endclass

module stereo_flanger_top_tb;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_write;
    logic [sflg_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [sflg_pkg::CFG_W-1:0]           cfg_data;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [sflg_pkg::SAMPLE_W-1:0] left_in;
    logic signed [sflg_pkg::SAMPLE_W-1:0] right_in;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [sflg_pkg::SAMPLE_W-1:0] left_out;
    logic signed [sflg_pkg::SAMPLE_W-1:0] right_out;

    flanger_scoreboard scb;
    int unsigned cycle_count;
    bit          calm_sink;
    bit          hold_sink;
    int unsigned hold_cycles;
    int unsigned settings_used;

    stereo_flanger_top u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        scb = new();
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("stereo_flanger_top: mismatch");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            scb.check_output(left_out, right_out);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_sink)
            out_stall <= 1'b1;
        else
            out_stall <= calm_sink ? 1'b0 : ($urandom_range(99) < 21);
    end

    initial
    begin
        hold_sink = 1'b0;
        hold_cycles = 0;
        wait (cycle_count > 3000);
        hold_sink = 1'b1;
        while (hold_cycles < 300)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_sink = 1'b0;
    end

    task automatic write_register(logic [sflg_pkg::CFG_IDX_W-1:0] idx,
                                  logic [sflg_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        scb.set_register(idx, value);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pair(logic signed [sflg_pkg::SAMPLE_W-1:0] l,
                             logic signed [sflg_pkg::SAMPLE_W-1:0] r,
                             bit calm);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scb.note_input(l, r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (scb.left_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [sflg_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($urandom_range(511)) - 24'sd256;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n, bit calm);
        for (int i = 0; i < n; i++)
            send_pair(random_sample(), random_sample(), calm);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = sflg_pkg::REG_BASE_DELAY;
        cfg_data = '0;
        in_valid = 1'b0;
        left_in = '0;
        right_in = '0;
        calm_sink = 1'b0;
        settings_used = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, silence, alternating full scale
        send_pair(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_pair(-24'sh800000, -24'sh800000, 1'b0);
        send_pair(24'sh7FFFFF, -24'sh800000, 1'b0);
        send_pair('0, '0, 1'b0);
        send_pair(24'sh555555, -24'sh2AAAAB, 1'b0);
        send_pair(-24'sd1, 24'sd1, 1'b0);
        random_phase(250, 1'b0);
        drain();

        // zero base delay, frozen LFO and heavy feedback: allpass overshoot
        write_register(sflg_pkg::REG_BASE_DELAY, 21'd0);
        write_register(sflg_pkg::REG_LFO_AMP, 21'd0);
        write_register(sflg_pkg::REG_FEEDBACK, 21'hFFFF);
        write_register(sflg_pkg::REG_LFO_INC, 21'd0);
        write_register(sflg_pkg::REG_LFO_AMP, 21'h1FFFFF);
        settings_used++;
        for (int i = 0; i < 20; i++)
            send_pair(i[0] ? 24'sh7FFFFF : -24'sh800000,
                      i[1] ? 24'sh7FFFFF : -24'sh800000, 1'b0);
        drain();

        // delay near the full line, all bits set in all registers but the feedback
        write_register(sflg_pkg::REG_BASE_DELAY, 21'h1FFFFF);
        write_register(sflg_pkg::REG_LFO_INC, 21'h1FFFFF);
        write_register(sflg_pkg::REG_FEEDBACK, 21'd63570);
        write_register(sflg_pkg::REG_LFO_AMP, 21'h1FFFF);
        settings_used++;
        calm_sink = 1'b1;
        random_phase(300, 1'b1);
        calm_sink = 1'b0;
        drain();

        write_register(sflg_pkg::REG_BASE_DELAY, 21'd1229);
        write_register(sflg_pkg::REG_LFO_AMP, 21'd86016);
        write_register(sflg_pkg::REG_LFO_INC, 21'd1789570);
        write_register(sflg_pkg::REG_FEEDBACK, 21'd0);
        settings_used++;
        random_phase(300, 1'b0);
        drain();

        for (int k = 0; k < 4; k++)
        begin
            write_register(sflg_pkg::REG_BASE_DELAY, 21'($urandom_range(86016, 1229)));
            write_register(sflg_pkg::REG_LFO_AMP, 21'($urandom_range(86016)));
            write_register(sflg_pkg::REG_LFO_INC, 21'($urandom_range(1789570, 17896)));
            write_register(sflg_pkg::REG_FEEDBACK, 21'($urandom_range(65535)));
            settings_used++;
            random_phase(95, 1'b0);
            drain();
        end

        $display("%0d pairs checked over %0d register settings, incl. extremes and a long",
                 scb.pairs_checked, settings_used);
        $display("output hold-off of %0d cycles", hold_cycles);
        if (scb.mismatches == 0 && scb.left_expected.size() == 0)
            $display("stereo_flanger_top: match");
        else
            $display("stereo_flanger_top: mismatch");
        $finish;
    end
endmodule
